// ===== design/ic3_pkg.sv =====
// Shared types, constants and helpers for the 3x3 image filter.
package ic3_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int COEF_FRAC_BITS = 14;

  localparam int COEF_W   = 16;
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int TAPS     = 9;
  localparam int POS_W    = 10;
  localparam int DIM_W    = 11;
  localparam int KROW_W   = 3 * COEF_W;
  localparam int COL_W    = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int PROD_W   = CH_W + 1 + COEF_W;
  localparam int SUM_W    = PROD_W + 4;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd5;

  localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RESET = 48'h0000_4000_0000;

  localparam logic COLOR_GREY = 1'b0;
  localparam logic COLOR_RGB  = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] pixel_ch2;
    logic [CH_W-1:0] pixel_ch1;
    logic [CH_W-1:0] pixel_ch0;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_ch0;
    logic [CH_W-1:0]  out_ch1;
    logic [CH_W-1:0]  out_ch2;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_of_frame;
  } result_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] window_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } meta_t;

  // What one cell hands to the next: position tag, remaining taps, running sums
  typedef struct packed {
    meta_t          meta;
    window_t        window;
    sum_t [2:0]     sums;
  } cell_bus_t;

  // Truncate toward zero and saturate to 0..255
  function automatic logic [CH_W-1:0] sat_channel(sum_t s);
    logic [SUM_W-COEF_FRAC_BITS-1:0] q;
    logic [CH_W-1:0]                 r;
    q = s[SUM_W-1:COEF_FRAC_BITS];
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (q > (SUM_W-COEF_FRAC_BITS)'(255)) begin
      r = 8'd255;
    end else begin
      r = q[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/image_convolution_3x3.sv =====
// A pixel beat is registered in stage A, stage B, each MAC cell and the output register.
// Throughput: one pixel per clock unless a result stalls; nine MAC cells, one per tap.
// The first two padded rows and columns of each frame produce no result.
// Reset (synchronous) restores register defaults, clears the window, counters and valids.
// Line stores are not cleared; entries read before they are written never reach a result.
// A stalled result holds the whole chain and the input side together.
module image_convolution_3x3 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  ic3_pkg::pixel_t                   pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output ic3_pkg::result_t                  result,
  input  logic                              cfg_write_en,
  input  logic [ic3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ic3_pkg::KROW_W-1:0]        cfg_data
);

  logic                          color_mode;
  logic [ic3_pkg::DIM_W-1:0]     image_width, image_height;
  logic [ic3_pkg::KROW_W-1:0]    kernel [3];
  logic                          advance, accept, pos_clear;
  ic3_pkg::cell_bus_t            chain [ic3_pkg::TAPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= ic3_pkg::COLOR_GREY;
      image_width  <= ic3_pkg::DIM_W'(1024);
      image_height <= ic3_pkg::DIM_W'(1024);
      kernel[0]    <= '0;
      kernel[1]    <= ic3_pkg::KERNEL_MIDDLE_RESET;
      kernel[2]    <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ic3_pkg::REG_COLOR_MODE:    color_mode   <= cfg_data[0];
        ic3_pkg::REG_IMAGE_WIDTH:   image_width  <= cfg_data[ic3_pkg::DIM_W-1:0];
        ic3_pkg::REG_IMAGE_HEIGHT:  image_height <= cfg_data[ic3_pkg::DIM_W-1:0];
        ic3_pkg::REG_KERNEL_TOP:    kernel[0]    <= cfg_data;
        ic3_pkg::REG_KERNEL_MIDDLE: kernel[1]    <= cfg_data;
        ic3_pkg::REG_KERNEL_BOTTOM: kernel[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_clear = cfg_write_en &&
                     (cfg_index == ic3_pkg::REG_IMAGE_WIDTH ||
                      cfg_index == ic3_pkg::REG_IMAGE_HEIGHT);

  assign advance     = !(result_valid && result_stall);
  assign pixel_stall = !advance;
  assign accept      = pixel_valid && advance;

  ic3_window u_window (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .accept       (accept),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .pos_clear    (pos_clear),
    .bus          (chain[0])
  );

  for (genvar k = 0; k < ic3_pkg::TAPS; k++) begin : g_cell
    localparam int KR = k / 3;
    localparam int KC = k % 3;

    ic3_mac_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .coef    (ic3_pkg::coef_t'(kernel[KR][KC*ic3_pkg::COEF_W +: ic3_pkg::COEF_W])),
      .bus_in  (chain[k]),
      .bus_out (chain[k+1])
    );
  end

  // Output register: saturate and drop the unused channels in grey mode
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= chain[ic3_pkg::TAPS].meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_ch0 <= ic3_pkg::sat_channel(chain[ic3_pkg::TAPS].sums[0]);
      if (color_mode == ic3_pkg::COLOR_RGB) begin
        result.out_ch1 <= ic3_pkg::sat_channel(chain[ic3_pkg::TAPS].sums[1]);
        result.out_ch2 <= ic3_pkg::sat_channel(chain[ic3_pkg::TAPS].sums[2]);
      end else begin
        result.out_ch1 <= '0;
        result.out_ch2 <= '0;
      end
      result.out_row       <= chain[ic3_pkg::TAPS].meta.row;
      result.out_col       <= chain[ic3_pkg::TAPS].meta.col;
      result.last_of_frame <= chain[ic3_pkg::TAPS].meta.last;
    end
  end

endmodule

// ===== design/ic3_line_store.sv =====
// One line store: a row of padded pixels with registered read.
module ic3_line_store (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ic3_pkg::COL_W-1:0]     rd_addr,
  output logic [ic3_pkg::PIX_W-1:0]     rd_data,
  input  logic                          wr_en,
  input  logic [ic3_pkg::COL_W-1:0]     wr_addr,
  input  logic [ic3_pkg::PIX_W-1:0]     wr_data
);

  logic [ic3_pkg::PIX_W-1:0] mem [ic3_pkg::MAX_WIDTH+2];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ic3_window.sv =====
// Front end: padded position counters, two line stores and the 3x3 window.
module ic3_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          accept,
  input  ic3_pkg::pixel_t               pixel,
  input  logic [ic3_pkg::DIM_W-1:0]     image_width,
  input  logic [ic3_pkg::DIM_W-1:0]     image_height,
  input  logic                          pos_clear,
  output ic3_pkg::cell_bus_t            bus
);

  logic [ic3_pkg::COL_W-1:0] col, col_next, col_cur, w_eff, w_plus2;
  logic [ic3_pkg::ROW_W-1:0] row, row_next, row_cur, h_eff, h_plus2;
  logic                      start_over, last_col, last_row;

  logic                      a_valid, a_emit, a_last;
  logic [ic3_pkg::PIX_W-1:0] a_pix;
  logic [ic3_pkg::COL_W-1:0] a_col, a_col_off;
  logic [ic3_pkg::ROW_W-1:0] a_row, a_row_off;

  logic [ic3_pkg::PIX_W-1:0] rd_above, rd_two_above;
  logic                      wr_en;

  ic3_pkg::window_t window;
  ic3_pkg::meta_t   meta;

  always_comb begin
    if (image_width == '0) begin
      w_eff = ic3_pkg::COL_W'(1);
    end else if (ic3_pkg::COL_W'(image_width) > ic3_pkg::COL_W'(ic3_pkg::MAX_WIDTH)) begin
      w_eff = ic3_pkg::COL_W'(ic3_pkg::MAX_WIDTH);
    end else begin
      w_eff = ic3_pkg::COL_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = ic3_pkg::ROW_W'(1);
    end else if (ic3_pkg::ROW_W'(image_height) > ic3_pkg::ROW_W'(ic3_pkg::MAX_HEIGHT)) begin
      h_eff = ic3_pkg::ROW_W'(ic3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = ic3_pkg::ROW_W'(image_height);
    end
    w_plus2    = w_eff + ic3_pkg::COL_W'(2);
    h_plus2    = h_eff + ic3_pkg::ROW_W'(2);
    start_over = (col >= w_plus2) || (row >= h_plus2);
    col_cur    = start_over ? '0 : col;
    row_cur    = start_over ? '0 : row;
    last_col   = (col_cur == w_eff + ic3_pkg::COL_W'(1));
    last_row   = (row_cur == h_eff + ic3_pkg::ROW_W'(1));
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row_cur + ic3_pkg::ROW_W'(1);
    end else begin
      col_next = col_cur + ic3_pkg::COL_W'(1);
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || pos_clear) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Stage A: hold the beat while the line stores are read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix  <= ic3_pkg::PIX_W'(pixel);
      a_col  <= col_cur;
      a_row  <= row_cur;
      a_emit <= (row_cur >= ic3_pkg::ROW_W'(2)) && (col_cur >= ic3_pkg::COL_W'(2));
      a_last <= last_col && last_row;
    end
  end

  assign wr_en = advance && a_valid;

  ic3_line_store u_above (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (rd_above),
    .wr_en   (wr_en),
    .wr_addr (a_col),
    .wr_data (a_pix)
  );

  ic3_line_store u_two_above (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (rd_two_above),
    .wr_en   (wr_en),
    .wr_addr (a_col),
    .wr_data (rd_above)
  );

  // Stage B: slide the window and tag the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (wr_en) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= rd_two_above;
      window[3] <= window[4];
      window[4] <= window[5];
      window[5] <= rd_above;
      window[6] <= window[7];
      window[7] <= window[8];
      window[8] <= a_pix;
    end
  end

  assign a_row_off = a_row - ic3_pkg::ROW_W'(2);
  assign a_col_off = a_col - ic3_pkg::COL_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      meta.valid <= 1'b0;
    end else if (advance) begin
      meta.valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      meta.row  <= a_row_off[ic3_pkg::POS_W-1:0];
      meta.col  <= a_col_off[ic3_pkg::POS_W-1:0];
      meta.last <= a_last;
    end
  end

  always_comb begin
    bus.meta   = meta;
    bus.window = window;
    bus.sums   = '0;
  end

endmodule

// ===== design/ic3_mac_cell.sv =====
// Multiply-accumulate cell: adds one tap times its coefficient, passes the rest on.
module ic3_mac_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  ic3_pkg::coef_t       coef,
  input  ic3_pkg::cell_bus_t   bus_in,
  output ic3_pkg::cell_bus_t   bus_out
);

  logic signed [ic3_pkg::PROD_W-1:0] prod [3];
  logic [ic3_pkg::PIX_W-1:0]         tap;
  ic3_pkg::sum_t [2:0]               sums_next;

  assign tap = bus_in.window[0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]      = $signed({1'b0, tap[c*ic3_pkg::CH_W +: ic3_pkg::CH_W]}) * coef;
      sums_next[c] = bus_in.sums[c] + ic3_pkg::SUM_W'(prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.meta.valid <= 1'b0;
    end else if (advance) begin
      bus_out.meta.valid <= bus_in.meta.valid;
    end
  end

  // Shift the remaining taps down so the next cell reads slot zero
  always_ff @(posedge clk) begin
    if (advance) begin
      bus_out.meta.row  <= bus_in.meta.row;
      bus_out.meta.col  <= bus_in.meta.col;
      bus_out.meta.last <= bus_in.meta.last;
      bus_out.window    <= {{ic3_pkg::PIX_W{1'b0}}, bus_in.window[ic3_pkg::TAPS-1:1]};
      bus_out.sums      <= sums_next;
    end
  end

endmodule

// ===== dv/ic3_filter_checker.sv =====
// Checker for the 3x3 image filter: mirrors its window and line stores and compares every result beat.
module ic3_filter_checker
  import ic3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  input  logic                 pixel_stall,
  input  pixel_t               pixel,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KROW_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic              rgb_mode;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [KROW_W-1:0] kernel_rows [0:2];
  logic [PIX_W-1:0]  line_above     [0:MAX_WIDTH+1];
  logic [PIX_W-1:0]  line_two_above [0:MAX_WIDTH+1];
  logic [PIX_W-1:0]  taps [0:TAPS-1];
  int unsigned       pad_col;
  int unsigned       pad_row;
  int                beat_count;
  result_t           filtered_q [$];

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Weighted sum of one channel over the window, truncated toward zero and saturated
  function automatic logic [CH_W-1:0] weigh_channel(int ch);
    longint acc;
    longint coef;
    longint px;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        coef = longint'($signed(kernel_rows[k][COEF_W*l +: COEF_W]));
        px   = longint'(taps[k*3+l][CH_W*ch +: CH_W]);
        acc  = acc + px * coef;
      end
    end
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > 255) return 8'd255;
    return acc[CH_W-1:0];
  endfunction

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
    case (idx)
      REG_COLOR_MODE: rgb_mode = data[0];
      REG_IMAGE_WIDTH: begin
        width_reg = data[DIM_W-1:0];
        pad_col   = 0;
        pad_row   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[DIM_W-1:0];
        pad_col    = 0;
        pad_row    = 0;
      end
      REG_KERNEL_TOP:    kernel_rows[0] = data;
      REG_KERNEL_MIDDLE: kernel_rows[1] = data;
      REG_KERNEL_BOTTOM: kernel_rows[2] = data;
      default: ;
    endcase
  endtask

  task automatic shift_in_pixel(pixel_t p);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] two_above;
    result_t          want;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = pad_col;
    r = pad_row;
    if (c >= w + 2 || r >= h + 2) begin
      c = 0;
      r = 0;
    end
    px        = p;
    above     = line_above[c];
    two_above = line_two_above[c];
    for (int k = 0; k < 3; k++) begin
      taps[3*k]   = taps[3*k+1];
      taps[3*k+1] = taps[3*k+2];
    end
    taps[2] = two_above;
    taps[5] = above;
    taps[8] = px;
    line_two_above[c] = above;
    line_above[c]     = px;
    if (r >= 2 && c >= 2) begin
      want.out_ch0       = weigh_channel(0);
      want.out_ch1       = rgb_mode ? weigh_channel(1) : '0;
      want.out_ch2       = rgb_mode ? weigh_channel(2) : '0;
      want.out_row       = POS_W'(r - 2);
      want.out_col       = POS_W'(c - 2);
      want.last_of_frame = (c == w + 1) && (r == h + 1);
      filtered_q.push_back(want);
    end
    // advance the padded position, wrap at the frame end
    if (c == w + 1) begin
      c = 0;
      r = (r == h + 1) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    pad_col = c;
    pad_row = r;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    beat_count++;
    if (filtered_q.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("result beat %0d with no filtered pixel pending: ch %0d %0d %0d row %0d col %0d",
                 beat_count, got.out_ch0, got.out_ch1, got.out_ch2, got.out_row, got.out_col);
    end else begin
      want = filtered_q.pop_front();
      if (got.out_ch0 !== want.out_ch0 || got.out_ch1 !== want.out_ch1 ||
          got.out_ch2 !== want.out_ch2 || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last_of_frame !== want.last_of_frame) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $write("result beat %0d: expected ch %0d %0d %0d row %0d col %0d last %0b,",
                 beat_count, want.out_ch0, want.out_ch1, want.out_ch2, want.out_row,
                 want.out_col, want.last_of_frame);
          $display(" got ch %0d %0d %0d row %0d col %0d last %0b",
                   got.out_ch0, got.out_ch1, got.out_ch2,
                   got.out_row, got.out_col, got.last_of_frame);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rgb_mode       = COLOR_GREY;
      width_reg      = DIM_W'(MAX_WIDTH);
      height_reg     = DIM_W'(MAX_HEIGHT);
      kernel_rows[0] = '0;
      kernel_rows[1] = KERNEL_MIDDLE_RESET;
      kernel_rows[2] = '0;
      for (int i = 0; i < MAX_WIDTH + 2; i++) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      for (int i = 0; i < TAPS; i++) taps[i] = '0;
      pad_col = 0;
      pad_row = 0;
      filtered_q.delete();
    end else begin
      // a result beat always belongs to an older pixel, so check before predicting
      if (result_valid && !result_stall) check_result(result);
      if (cfg_write_en) write_setting(cfg_index, cfg_data);
      if (pixel_valid && !pixel_stall) shift_in_pixel(pixel);
    end
    pending = filtered_q.size();
  end

endmodule

// ===== dv/image_convolution_3x3_tb.sv =====
// Stimulus and verdict for the 3x3 image filter: directed frames, random frames, stalls.
module image_convolution_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ic3_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int GAP_MAX       = 10;
  localparam int RANDOM_ITEMS  = 750;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SLICE_ITEMS   = 64;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 pixel_valid  = 1'b0;
  logic                 pixel_stall;
  pixel_t               pixel        = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_COLOR_MODE;
  logic [KROW_W-1:0]    cfg_data     = '0;

  int                   fail_count;
  int                   pending;
  int unsigned          tx_gap_max   = GAP_MAX;
  int unsigned          rx_gap_max   = GAP_MAX;
  int                   hold_req     = 0;
  int                   hold_done    = 0;
  int unsigned          eff_w        = MAX_WIDTH;
  int unsigned          eff_h        = MAX_HEIGHT;

  image_convolution_3x3 i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ic3_filter_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic pixel_t random_pixel();
    logic [PIX_W-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 7))
        0:       p[CH_W*ch +: CH_W] = 8'd0;
        1:       p[CH_W*ch +: CH_W] = 8'd255;
        default: p[CH_W*ch +: CH_W] = CH_W'($urandom_range(0, 255));
      endcase
    end
    return pixel_t'(p);
  endfunction

  // Mostly small blur-like weights, some extremes, some fully random
  function automatic logic [KROW_W-1:0] random_kernel_row();
    logic [KROW_W-1:0] row;
    logic [COEF_W-1:0] c;
    int                style;
    style = $urandom_range(0, 5);
    for (int l = 0; l < 3; l++) begin
      if (style == 0) begin
        c = COEF_W'($urandom_range(0, 65535));
      end else if (style == 1) begin
        case ($urandom_range(0, 4))
          0:       c = 16'h7FFF;
          1:       c = 16'h8000;
          2:       c = 16'h0000;
          3:       c = 16'h4000;
          default: c = 16'hFFFF;
        endcase
      end else begin
        c = COEF_W'($urandom_range(0, 16'h0C00));
        if ($urandom_range(0, 3) == 0) c = -c;
      end
      row[COEF_W*l +: COEF_W] = c;
    end
    return row;
  endfunction

  // Leaves the write enable high; the caller drops it after the last write
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    if (idx == REG_IMAGE_WIDTH) eff_w = clamp_dim(data[DIM_W-1:0], MAX_WIDTH);
    if (idx == REG_IMAGE_HEIGHT) eff_h = clamp_dim(data[DIM_W-1:0], MAX_HEIGHT);
    @(negedge clk);
  endtask

  task automatic send_pixel(pixel_t p);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_pixel(random_pixel());
  endtask

  // Hold the sender until every expected result has left, then let the pipe settle
  task automatic drain_block();
    pixel_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stall before each beat, long hold-off on request
  initial begin
    int unsigned gap;
    int unsigned beats;
    beats = 0;
    @(negedge clk);
    forever begin
      if (hold_req != hold_done) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        result_stall <= 1'b0;
        hold_done++;
      end else begin
        gap = $urandom_range(0, rx_gap_max);
        if (gap != 0) begin
          result_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          result_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
      beats++;
      if (beats % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_gap_max = 0;
          1:       rx_gap_max = 3;
          default: rx_gap_max = GAP_MAX;
        endcase
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [PIX_W-1:0] grey_frame  [0:8];
    logic [PIX_W-1:0] color_frame [0:8];
    int unsigned      rand_sent;
    int unsigned      phase;
    int unsigned      frame;
    int unsigned      n;
    int unsigned      waited;
    logic [DIM_W-1:0] dim;

    grey_frame  = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'hFFFFFF,
                    24'h0000FF, 24'h123456, 24'h0000FF, 24'hFFFF00};
    // top row drives red negative, bottom row saturates green, blue stays tiny
    color_frame = '{24'h0000FF, 24'h0000FF, 24'h0000FF, 24'hFF0000, 24'h010000,
                    24'h000000, 24'h00FF00, 24'h00FF00, 24'h00FF00};

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // grey mode, zero sizes act as one pixel, plain pass-through kernel
    set_reg(REG_COLOR_MODE, KROW_W'(COLOR_GREY));
    set_reg(REG_IMAGE_WIDTH, '0);
    set_reg(REG_IMAGE_HEIGHT, '0);
    set_reg(REG_KERNEL_TOP, '0);
    set_reg(REG_KERNEL_MIDDLE, KERNEL_MIDDLE_RESET);
    set_reg(REG_KERNEL_BOTTOM, '0);
    cfg_write_en <= 1'b0;
    for (int i = 0; i < 9; i++) send_pixel(pixel_t'(grey_frame[i]));
    drain_block();

    // rgb mode with coefficient extremes: clamp low, saturate high, truncate
    set_reg(REG_COLOR_MODE, KROW_W'(COLOR_RGB));
    set_reg(REG_IMAGE_WIDTH, KROW_W'(1));
    set_reg(REG_IMAGE_HEIGHT, KROW_W'(1));
    set_reg(REG_KERNEL_TOP, 48'h8000_8000_8000);
    set_reg(REG_KERNEL_MIDDLE, 48'h0000_7FFF_0001);
    set_reg(REG_KERNEL_BOTTOM, 48'h7FFF_7FFF_7FFF);
    cfg_write_en <= 1'b0;
    for (int i = 0; i < 9; i++) send_pixel(pixel_t'(color_frame[i]));

    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RANDOM_ITEMS || phase < 9) begin
      drain_block();
      if (phase == 2 || phase == 5) begin
        // start of the widest row, then of the tallest frame; sizes above the maximum clamp
        tx_gap_max = 0;
        set_reg(REG_COLOR_MODE, KROW_W'($urandom_range(0, 1)));
        set_reg(REG_IMAGE_WIDTH, (phase == 2) ? KROW_W'(2047) : KROW_W'(1));
        set_reg(REG_IMAGE_HEIGHT, (phase == 2) ? KROW_W'(1) : KROW_W'(1100));
        set_reg(REG_KERNEL_MIDDLE, random_kernel_row());
        cfg_write_en <= 1'b0;
        n = SLICE_ITEMS;
        send_random(n);
        rand_sent += n;
      end else if (phase == 3 || phase == 8) begin
        // back-to-back pixels while the receiver holds off, so the input stalls
        tx_gap_max = 0;
        set_reg(REG_IMAGE_WIDTH, KROW_W'(10));
        set_reg(REG_IMAGE_HEIGHT, KROW_W'(8));
        set_reg(REG_KERNEL_TOP, random_kernel_row());
        cfg_write_en <= 1'b0;
        hold_req++;
        n = 2 * (eff_w + 2) * (eff_h + 2);
        send_random(n);
        rand_sent += n;
      end else begin
        tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
        if (phase == 0 || $urandom_range(0, 1) == 1)
          set_reg(REG_COLOR_MODE, KROW_W'($urandom_range(0, 1)));
        if (phase == 0 || $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 9))
            0:       dim = '0;
            1:       dim = DIM_W'($urandom_range(7, 24));
            default: dim = DIM_W'($urandom_range(1, 6));
          endcase
          set_reg(REG_IMAGE_WIDTH, KROW_W'(dim));
        end
        if (phase == 0 || $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 9))
            0:       dim = '0;
            1:       dim = DIM_W'($urandom_range(6, 10));
            default: dim = DIM_W'($urandom_range(1, 5));
          endcase
          set_reg(REG_IMAGE_HEIGHT, KROW_W'(dim));
        end
        if (phase == 0 || $urandom_range(0, 1) == 1) set_reg(REG_KERNEL_TOP, random_kernel_row());
        if (phase == 0 || $urandom_range(0, 1) == 1)
          set_reg(REG_KERNEL_MIDDLE, random_kernel_row());
        if (phase == 0 || $urandom_range(0, 1) == 1)
          set_reg(REG_KERNEL_BOTTOM, random_kernel_row());
        cfg_write_en <= 1'b0;
        // whole frames mostly, some cut short, some running into the next frame
        frame = (eff_w + 2) * (eff_h + 2);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: n = frame * $urandom_range(1, 2);
          6, 7:             n = $urandom_range(1, frame);
          default:          n = frame + $urandom_range(1, frame);
        endcase
        send_random(n);
        rand_sent += n;
      end
      phase++;
    end

    pixel_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
